// File: rtl/gdod_pkg.sv
// ----------------------------------------------------------------------------
// gdod_pkg
// Widths, division constants and the month offset table for the Gregorian
// date shift and difference core.
// ----------------------------------------------------------------------------
package gdod_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OFF_W   = 23;

	localparam int YEAR_BIAS    = 40000;
	localparam int DAYS_PER_ERA = 146097;
	localparam int YEARS_PER_ERA = 400;
	localparam int DAYS_PER_YEAR = 365;

	localparam logic signed [OFF_W-1:0] DIFF_MAX = 23'sh3FFFFF;
	localparam logic signed [OFF_W-1:0] DIFF_MIN = -23'sh400000;

	// reciprocals for constant division: floor(x/d) = (x*M) >> K
	localparam longint unsigned M100_L   = (64'd1 << 24) / 100 + 1;
	localparam longint unsigned MERA_L   = (64'd1 << 44) / DAYS_PER_ERA + 1;
	localparam longint unsigned M1460_L  = (64'd1 << 40) / 1460 + 1;
	localparam longint unsigned M36524_L = (64'd1 << 40) / 36524 + 1;
	localparam longint unsigned M365_L   = (64'd1 << 40) / DAYS_PER_YEAR + 1;
	localparam longint unsigned M153_L   = (64'd1 << 22) / 153 + 1;

	localparam logic [17:0] M100   = M100_L[17:0];
	localparam logic [26:0] MERA   = MERA_L[26:0];
	localparam logic [29:0] M1460  = M1460_L[29:0];
	localparam logic [24:0] M36524 = M36524_L[24:0];
	localparam logic [31:0] M365   = M365_L[31:0];
	localparam logic [14:0] M153   = M153_L[14:0];

	typedef struct packed {
		logic signed [OFF_W-1:0] diff;
		logic                    after;
		logic                    equal;
	} side_t;

	// days before the first of a March-based month: (153*mp+2)/5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/gdod_in_if.sv
// ----------------------------------------------------------------------------
// gdod_in_if
// Input channel: two dates and a signed day offset.
// ----------------------------------------------------------------------------
interface gdod_in_if;
	import gdod_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [YEAR_W-1:0]         a_year;
	logic [MONTH_W-1:0]        a_month;
	logic [DAY_W-1:0]          a_day;
	logic [YEAR_W-1:0]         b_year;
	logic [MONTH_W-1:0]        b_month;
	logic [DAY_W-1:0]          b_day;
	logic signed [OFF_W-1:0]   offset_days;

	modport source(output valid, a_year, a_month, a_day, b_year, b_month, b_day,
		offset_days, input ready);
	modport sink(input valid, a_year, a_month, a_day, b_year, b_month, b_day,
		offset_days, output ready);
endinterface

// File: rtl/gdod_out_if.sv
// ----------------------------------------------------------------------------
// gdod_out_if
// Result channel: shifted date, day difference and comparison flags.
// ----------------------------------------------------------------------------
interface gdod_out_if;
	import gdod_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [YEAR_W-1:0]         res_year;
	logic [MONTH_W-1:0]        res_month;
	logic [DAY_W-1:0]          res_day;
	logic signed [OFF_W-1:0]   days_between;
	logic                      a_after_b;
	logic                      a_equals_b;
	logic                      out_of_range;

	modport source(output valid, res_year, res_month, res_day, days_between,
		a_after_b, a_equals_b, out_of_range, input ready);
	modport sink(input valid, res_year, res_month, res_day, days_between,
		a_after_b, a_equals_b, out_of_range, output ready);
endinterface

// File: rtl/gregorian_date_offset_and_diff_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset_and_diff_core
// Shifts date A by a signed day offset and returns A minus B in days.
// ----------------------------------------------------------------------------
// Ten-stage pipeline, one word per cycle unless the result side stalls. Both
// dates become linear day numbers (stages 1-2), the offset is added (stage 3)
// and the sum is taken back to year, month and day through constant-reciprocal
// multiplies (stages 4-10). A stall on the result side freezes every stage
// at once, so ready follows the result side combinationally.
module gregorian_date_offset_and_diff_core (
	input  logic           clk,
	input  logic           arst_n,
	gdod_in_if.sink        dates,
	gdod_out_if.source     result
);
	import gdod_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	assign adv = !v_s10 || result.ready;
	assign dates.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (adv) begin
			v_s1  <= dates.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// ---------------- stage 1: clamp month, bias year ----------------
	logic [3:0]  ma_c, mb_c, mpa, mpb;
	logic        loa, lob;
	logic [15:0] yya, yyb;
	logic [9:0]  mda, mdb;
	logic        after_c, equal_c;

	always_comb begin
		ma_c = (dates.a_month == 4'd0) ? 4'd1 : (dates.a_month > 4'd12) ? 4'd12 : dates.a_month;
		mb_c = (dates.b_month == 4'd0) ? 4'd1 : (dates.b_month > 4'd12) ? 4'd12 : dates.b_month;
		loa  = ma_c <= 4'd2;
		lob  = mb_c <= 4'd2;
		yya  = {2'b00, dates.a_year} + 16'(YEAR_BIAS) - {15'b0, loa};
		yyb  = {2'b00, dates.b_year} + 16'(YEAR_BIAS) - {15'b0, lob};
		mpa  = loa ? ma_c + 4'd9 : ma_c - 4'd3;
		mpb  = lob ? mb_c + 4'd9 : mb_c - 4'd3;
		mda  = {1'b0, month_start(mpa)} + {5'b0, dates.a_day};
		mdb  = {1'b0, month_start(mpb)} + {5'b0, dates.b_day};
		equal_c = (dates.a_year == dates.b_year) && (dates.a_month == dates.b_month)
			&& (dates.a_day == dates.b_day);
		if (dates.a_year != dates.b_year)
			after_c = dates.a_year > dates.b_year;
		else if (dates.a_month != dates.b_month)
			after_c = dates.a_month > dates.b_month;
		else
			after_c = dates.a_day > dates.b_day;
	end

	logic [15:0] yya_s1, yyb_s1;
	logic [33:0] pa_s1, pb_s1;
	logic [9:0]  mda_s1, mdb_s1;
	logic signed [OFF_W-1:0] off_s1, off_s2;
	logic        after_s1, equal_s1, after_s2, equal_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			yya_s1   <= yya;
			yyb_s1   <= yyb;
			pa_s1    <= {18'b0, yya} * {16'b0, M100};
			pb_s1    <= {18'b0, yyb} * {16'b0, M100};
			mda_s1   <= mda;
			mdb_s1   <= mdb;
			off_s1   <= dates.offset_days;
			after_s1 <= after_c;
			equal_s1 <= equal_c;
		end
	end

	// ---------------- stage 2: day numbers ----------------
	logic [9:0]  qa100, qb100;
	logic [24:0] na, nb, na_s2, nb_s2;

	always_comb begin
		qa100 = pa_s1[33:24];
		qb100 = pb_s1[33:24];
		na = 25'd365 * {9'b0, yya_s1} + {11'b0, yya_s1[15:2]} - {15'b0, qa100}
			+ {17'b0, qa100[9:2]} + {15'b0, mda_s1} - 25'd1;
		nb = 25'd365 * {9'b0, yyb_s1} + {11'b0, yyb_s1[15:2]} - {15'b0, qb100}
			+ {17'b0, qb100[9:2]} + {15'b0, mdb_s1} - 25'd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s2    <= na;
			nb_s2    <= nb;
			off_s2   <= off_s1;
			after_s2 <= after_s1;
			equal_s2 <= equal_s1;
		end
	end

	// ---------------- stage 3: add offset, difference ----------------
	logic signed [25:0] zs, dd;
	side_t side_c;
	logic [24:0] z_s3, z_s4;
	side_t side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;

	always_comb begin
		zs = $signed({1'b0, na_s2}) + 26'(off_s2);
		dd = $signed({1'b0, na_s2}) - $signed({1'b0, nb_s2});
		if (dd > 26'(DIFF_MAX))
			side_c.diff = DIFF_MAX;
		else if (dd < 26'(DIFF_MIN))
			side_c.diff = DIFF_MIN;
		else
			side_c.diff = dd[OFF_W-1:0];
		side_c.after = after_s2;
		side_c.equal = equal_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s3    <= zs[24:0];
			side_s3 <= side_c;
		end
	end

	// ---------------- stage 4: era reciprocal product ----------------
	logic [51:0] pera_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pera_s4 <= {27'b0, z_s3} * {25'b0, MERA};
			z_s4    <= z_s3;
			side_s4 <= side_s3;
		end
	end

	// ---------------- stage 5: era and day of era ----------------
	logic [7:0]  era_c, era_s5, era_s6, era_s7, era_s8, era_s9;
	logic [25:0] era_days;
	logic [17:0] doe_s5, doe_s6, doe_s7, doe_s8;

	always_comb begin
		era_c    = pera_s4[51:44];
		era_days = {18'b0, era_c} * 26'(DAYS_PER_ERA);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			era_s5  <= era_c;
			doe_s5  <= 18'({1'b0, z_s4} - era_days);
			side_s5 <= side_s4;
		end
	end

	// ---------------- stage 6: leap correction products ----------------
	logic [47:0] p1460_s6;
	logic [42:0] p36524_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1460_s6  <= {30'b0, doe_s5} * {18'b0, M1460};
			p36524_s6 <= {25'b0, doe_s5} * {18'b0, M36524};
			doe_s6    <= doe_s5;
			era_s6    <= era_s5;
			side_s6   <= side_s5;
		end
	end

	// ---------------- stage 7: corrected day of era ----------------
	logic [17:0] num_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7  <= doe_s6 - {10'b0, p1460_s6[47:40]} + {15'b0, p36524_s6[42:40]}
				- {17'b0, (doe_s6 == 18'(DAYS_PER_ERA - 1))};
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;
			side_s7 <= side_s6;
		end
	end

	// ---------------- stage 8: year of era product ----------------
	logic [49:0] p365_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			p365_s8 <= {32'b0, num_s7} * {18'b0, M365};
			doe_s8  <= doe_s7;
			era_s8  <= era_s7;
			side_s8 <= side_s7;
		end
	end

	// ---------------- stage 9: day of year ----------------
	logic [8:0]  yoe_c, yoe_s9, doy_s9;
	logic [1:0]  c100;
	logic [17:0] ystart;

	always_comb begin
		yoe_c  = p365_s8[48:40];
		c100   = 2'(yoe_c >= 9'd100) + 2'(yoe_c >= 9'd200) + 2'(yoe_c >= 9'd300);
		ystart = 18'd365 * {9'b0, yoe_c} + {11'b0, yoe_c[8:2]} - {16'b0, c100};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yoe_s9  <= yoe_c;
			doy_s9  <= 9'(doe_s8 - ystart);
			era_s9  <= era_s8;
			side_s9 <= side_s8;
		end
	end

	// ---------------- stage 10: month, day, year, range ----------------
	logic [10:0] t153;
	logic [25:0] p153;
	logic [3:0]  mp_c, mon_c;
	logic [4:0]  day_c;
	logic [16:0] yy_c;
	logic signed [17:0] ys;
	logic        oor_c;

	always_comb begin
		t153  = 11'd5 * {2'b0, doy_s9} + 11'd2;
		p153  = {15'b0, t153} * {11'b0, M153};
		mp_c  = p153[25:22];
		day_c = 5'(doy_s9 - month_start(mp_c) + 9'd1);
		mon_c = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
		yy_c  = {8'b0, yoe_s9} + {9'b0, era_s9} * 17'(YEARS_PER_ERA)
			+ {16'b0, (mon_c <= 4'd2)};
		ys    = $signed({1'b0, yy_c}) - 18'sd40000;
		oor_c = (ys < 18'sd1) || (ys > 18'sd9999);
	end

	logic [YEAR_W-1:0]  year_s10;
	logic [MONTH_W-1:0] mon_s10;
	logic [DAY_W-1:0]   day_s10;
	logic               oor_s10;
	side_t              side_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			year_s10 <= oor_c ? '0 : ys[YEAR_W-1:0];
			mon_s10  <= oor_c ? '0 : mon_c;
			day_s10  <= oor_c ? '0 : day_c;
			oor_s10  <= oor_c;
			side_s10 <= side_s9;
		end
	end

	assign result.valid        = v_s10;
	assign result.res_year     = year_s10;
	assign result.res_month    = mon_s10;
	assign result.res_day      = day_s10;
	assign result.days_between = side_s10.diff;
	assign result.a_after_b    = side_s10.after;
	assign result.a_equals_b   = side_s10.equal;
	assign result.out_of_range = oor_s10;

endmodule

// File: sim/gdod_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdod_tb_pkg
// Word types and the calendar arithmetic used to predict the date core.
// ----------------------------------------------------------------------------
package gdod_tb_pkg;
	import gdod_pkg::*;

	typedef struct packed {
		logic [YEAR_W-1:0]       a_year;
		logic [MONTH_W-1:0]      a_month;
		logic [DAY_W-1:0]        a_day;
		logic [YEAR_W-1:0]       b_year;
		logic [MONTH_W-1:0]      b_month;
		logic [DAY_W-1:0]        b_day;
		logic signed [OFF_W-1:0] offset_days;
	} date_word_t;

	typedef struct packed {
		logic [YEAR_W-1:0]       res_year;
		logic [MONTH_W-1:0]      res_month;
		logic [DAY_W-1:0]        res_day;
		logic signed [OFF_W-1:0] days_between;
		logic                    a_after_b;
		logic                    a_equals_b;
		logic                    out_of_range;
	} date_result_t;

	// biased, March-based linear day count; always positive
	function automatic longint linear_day(input logic [YEAR_W-1:0] y,
		input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
		longint yy, mm, mp;
		yy = y;
		mm = m;
		if (mm < 1) mm = 1;
		if (mm > 12) mm = 12;
		if (mm <= 2) yy = yy - 1;
		yy = yy + YEAR_BIAS;
		mp = (mm + 9) % 12;
		return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
	endfunction

	function automatic date_result_t shifted_date(input date_word_t w);
		date_result_t r;
		longint na, nb, z, era, doe, yoe, doy, mp, yy, dd, mm, diff;
		na = linear_day(w.a_year, w.a_month, w.a_day);
		nb = linear_day(w.b_year, w.b_month, w.b_day);
		z = na + longint'(w.offset_days);
		era = z / DAYS_PER_ERA;
		doe = z - era * DAYS_PER_ERA;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		yy = yoe + era * 400;
		dd = doy - (153 * mp + 2) / 5 + 1;
		mm = mp < 10 ? mp + 3 : mp - 9;
		if (mm <= 2) yy = yy + 1;
		yy = yy - YEAR_BIAS;
		r.out_of_range = (yy < 1 || yy > 9999);
		r.res_year  = r.out_of_range ? '0 : yy[YEAR_W-1:0];
		r.res_month = r.out_of_range ? '0 : mm[MONTH_W-1:0];
		r.res_day   = r.out_of_range ? '0 : dd[DAY_W-1:0];
		diff = na - nb;
		if (diff > 4194303) diff = 4194303;
		if (diff < -4194304) diff = -4194304;
		r.days_between = diff[OFF_W-1:0];
		r.a_equals_b = (w.a_year == w.b_year) && (w.a_month == w.b_month) &&
			(w.a_day == w.b_day);
		if (w.a_year != w.b_year) r.a_after_b = w.a_year > w.b_year;
		else if (w.a_month != w.b_month) r.a_after_b = w.a_month > w.b_month;
		else r.a_after_b = w.a_day > w.b_day;
		return r;
	endfunction

endpackage

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives date words into the date core with random gaps and result stalls,
// predicts each result and checks it field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import gdod_pkg::*;
	import gdod_tb_pkg::*;

	localparam int LATENCY = 10;
	localparam int N_RANDOM = 1200;

	logic clk;
	logic arst_n;

	gdod_in_if  dates();
	gdod_out_if result();

	gregorian_date_offset_and_diff_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.dates  (dates.sink),
		.result (result.source)
	);

	date_word_t   pending_words[$];
	date_result_t expected_results[$];
	int  n_errors = 0;
	int  n_checked = 0;
	int  n_oor = 0;
	bit  quiet = 0;          // no idling in the last part
	bit  drain_hold = 0;     // sender waits for all results
	int  long_stall = 0;     // long receiver hold-off, in cycles
	int  gap_left = 0;
	int  stall_left = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// driver
	initial begin
		dates.valid = 0;
		dates.a_year = '0; dates.a_month = '0; dates.a_day = '0;
		dates.b_year = '0; dates.b_month = '0; dates.b_day = '0;
		dates.offset_days = '0;
		result.ready = 0;
	end

	bit accepted_in;
	always @(posedge clk) accepted_in <= dates.valid && dates.ready;

	always @(negedge clk) begin
		if (arst_n) begin
			if (dates.valid && !accepted_in) begin
				// hold the word
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				dates.valid <= 0;
			end else if (drain_hold || pending_words.size() == 0) begin
				dates.valid <= 0;
			end else begin
				dates.valid <= 1;
				{dates.a_year, dates.a_month, dates.a_day, dates.b_year, dates.b_month,
					dates.b_day, dates.offset_days} <= pending_words[0];
				expected_results.push_back(shifted_date(pending_words[0]));
				void'(pending_words.pop_front());
				if (!quiet && $urandom_range(0, 9) == 0)
					gap_left <= $urandom_range(1, 13);
			end
		end
	end

	// receiver ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_stall > 0) begin
				long_stall <= long_stall - 1;
				result.ready <= 0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result.ready <= 0;
			end else begin
				result.ready <= 1;
				if (!quiet && $urandom_range(0, 9) == 0)
					stall_left <= $urandom_range(1, 13);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		date_result_t got, exp_r;
		if (arst_n && result.valid && result.ready) begin
			got = '{result.res_year, result.res_month, result.res_day,
				result.days_between, result.a_after_b, result.a_equals_b,
				result.out_of_range};
			if (expected_results.size() == 0) begin
				$error("unexpected result word");
				n_errors++;
			end else begin
				exp_r = expected_results.pop_front();
				n_checked++;
				if (exp_r.out_of_range) n_oor++;
				if (got.res_year !== exp_r.res_year) begin
					$error("res_year exp %0d got %0d", exp_r.res_year, got.res_year); n_errors++;
				end
				if (got.res_month !== exp_r.res_month) begin
					$error("res_month exp %0d got %0d", exp_r.res_month, got.res_month);
					n_errors++;
				end
				if (got.res_day !== exp_r.res_day) begin
					$error("res_day exp %0d got %0d", exp_r.res_day, got.res_day); n_errors++;
				end
				if (got.days_between !== exp_r.days_between) begin
					$error("days_between exp %0d got %0d", exp_r.days_between,
						got.days_between);
					n_errors++;
				end
				if (got.a_after_b !== exp_r.a_after_b) begin
					$error("a_after_b exp %0d got %0d", exp_r.a_after_b, got.a_after_b);
					n_errors++;
				end
				if (got.a_equals_b !== exp_r.a_equals_b) begin
					$error("a_equals_b exp %0d got %0d", exp_r.a_equals_b, got.a_equals_b);
					n_errors++;
				end
				if (got.out_of_range !== exp_r.out_of_range) begin
					$error("out_of_range exp %0d got %0d", exp_r.out_of_range,
						got.out_of_range);
					n_errors++;
				end
			end
		end
	end

	function automatic date_word_t mk(input int ay, am, ad, by, bm, bd, off);
		date_word_t w;
		w.a_year = YEAR_W'(ay); w.a_month = MONTH_W'(am); w.a_day = DAY_W'(ad);
		w.b_year = YEAR_W'(by); w.b_month = MONTH_W'(bm); w.b_day = DAY_W'(bd);
		w.offset_days = OFF_W'(off);
		return w;
	endfunction

	function automatic date_word_t random_word();
		date_word_t w;
		logic [95:0] noise;
		w = mk($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31),
			$urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31), 0);
		noise = {$urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0: w = noise[$bits(date_word_t)-1:0];   // raw noise, all bits
			1: w.offset_days = OFF_W'(int'($urandom_range(0, 200)) - 100);
			2: begin
				w.b_year = w.a_year; w.b_month = w.a_month;
				w.b_day = $urandom_range(0, 1) ? w.a_day : DAY_W'($urandom_range(0, 31));
				w.offset_days = OFF_W'($urandom);
			end
			3: begin
				w.a_year = $urandom_range(0, 1) ? YEAR_W'($urandom_range(1, 30))
					: YEAR_W'($urandom_range(9970, 9999));
				w.offset_days = OFF_W'(int'($urandom_range(0, 40000)) - 20000);
			end
			4: w.offset_days = $urandom_range(0, 1)
				? OFF_W'(int'(DIFF_MAX) - int'($urandom_range(0, 9)))
				: OFF_W'(int'(DIFF_MIN) + int'($urandom_range(0, 9)));
			default: w.offset_days = OFF_W'($urandom);
		endcase
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() != 0 || expected_results.size() != 0 || dates.valid)
			@(posedge clk);
	endtask

	initial begin
		int i;
		@(posedge arst_n);
		// directed: extremes, leap days, month and day corner cases
		pending_words.push_back(mk(1, 1, 1, 1, 1, 1, 0));
		pending_words.push_back(mk(9999, 12, 31, 1, 1, 1, 0));
		pending_words.push_back(mk(1, 1, 1, 9999, 12, 31, 0));
		pending_words.push_back(mk(1, 1, 1, 1, 1, 1, -1));
		pending_words.push_back(mk(9999, 12, 31, 1, 1, 1, 1));
		pending_words.push_back(mk(2000, 2, 28, 2000, 2, 29, 1));
		pending_words.push_back(mk(1900, 2, 28, 1900, 3, 1, 1));
		pending_words.push_back(mk(2024, 3, 1, 2024, 2, 29, -1));
		pending_words.push_back(mk(2023, 12, 31, 2024, 1, 1, 1));
		pending_words.push_back(mk(2023, 0, 15, 2023, 1, 15, 0));
		pending_words.push_back(mk(2023, 15, 15, 2023, 12, 15, 0));
		pending_words.push_back(mk(2023, 4, 0, 2023, 3, 31, 0));
		pending_words.push_back(mk(2023, 2, 31, 2023, 3, 3, 0));
		pending_words.push_back(mk(0, 6, 1, 16383, 6, 1, 0));
		pending_words.push_back(mk(16383, 15, 31, 0, 0, 0, 0));
		pending_words.push_back(mk(5000, 6, 15, 5000, 6, 15, 4194303));
		pending_words.push_back(mk(5000, 6, 15, 5000, 6, 14, -4194304));
		pending_words.push_back(mk(2000, 1, 1, 1999, 12, 31, 146097));
		pending_words.push_back(mk(1, 1, 1, 1, 1, 1, 3652058));
		pending_words.push_back(mk(9999, 12, 31, 9999, 12, 31, -3652059));
		wait_drained();
		// long receiver hold-off so the pipeline fills and back-pressures
		long_stall = 200;
		for (i = 0; i < 100; i++) pending_words.push_back(random_word());
		wait_drained();
		// sender pause until everything is back
		for (i = 0; i < N_RANDOM; i++) begin
			pending_words.push_back(random_word());
			if (i == N_RANDOM / 2) begin
				wait_drained();
				drain_hold = 1;
				repeat (20) @(posedge clk);
				drain_hold = 0;
			end
			if (i == N_RANDOM * 3 / 4) quiet = 1;
		end
		wait_drained();
		repeat (LATENCY + 5) @(posedge clk);
		$display("checked %0d result words, %0d out of range, over directed corners,",
			n_checked, n_oor);
		$display("random dates and offsets with gaps, stalls and back-pressure");
		if (n_errors == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule
